// File: sv/pn9_whiten_conv_fec_interleave_tx_macros.svh
// assertion macros for the transmit encoder's output buffer
`ifndef PN9_WHITEN_CONV_FEC_INTERLEAVE_TX_MACROS_SVH
`define PN9_WHITEN_CONV_FEC_INTERLEAVE_TX_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define PWCFI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pwcfi: check failed");

// condition in one cycle implies a consequence in the next
`define PWCFI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwcfi: next-cycle check failed");

`endif

// File: sv/pwcfi_pkg.sv
`default_nettype none
package pwcfi_pkg;

  // pn9 start value and trellis terminator byte
  localparam logic [8:0] LFSR_INIT  = 9'h1FF;
  localparam logic [7:0] TERMINATOR = 8'h0B;
  localparam logic [2:0] TERM_HIST  = TERMINATOR[2:0];

  // valid byte counts of a result item
  localparam logic [2:0] COUNT_PLAIN = 3'd1;
  localparam logic [2:0] COUNT_CODED = 3'd4;

  // output buffer depth
  localparam int unsigned OBUF_DEPTH = 2;

  // 2-bit symbol for each 4-bit window of history and data
  localparam logic [1:0] SYM_TABLE [16] = '{
    2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1,
    2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_frame;
    logic       last_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [2:0]  out_count;
    logic        out_last;
  } out_item_t;

  // encoder state carried from byte to byte
  typedef struct packed {
    logic [8:0]  lfsr;
    logic [2:0]  hist;
    logic [15:0] held;
    logic        phase;
  } coder_state_t;

  // results of one byte: count and up to two items
  typedef struct packed {
    logic [1:0] nres;
    out_item_t  r0;
    out_item_t  r1;
  } enc_res_t;

  // pn9 advance by eight steps, four at a time
  function automatic logic [8:0] lfsr_advance(input logic [8:0] r_in);
    logic [8:0] r;
    logic [8:0] fb;
    r = r_in;
    for (int n = 0; n < 2; n++) begin
      fb = ((r << 5) ^ r) & 9'h1E0;
      r  = (r >> 4) | fb;
    end
    return r;
  endfunction

  // rate one half code of one byte, msb first
  function automatic logic [15:0] code_byte(input logic [2:0] hist, input logic [7:0] v);
    logic [10:0] x;
    logic [15:0] acc;
    x   = {hist, v};
    acc = '0;
    for (int n = 0; n < 8; n++) begin
      acc[15 - 2*n -: 2] = SYM_TABLE[x[10 - n -: 4]];
    end
    return acc;
  endfunction

  // four coded bytes into one word, 2-bit groups
  function automatic logic [31:0] interleave(input logic [15:0] first,
                                             input logic [15:0] second);
    logic [7:0]  c [4];
    logic [31:0] w;
    c[0] = first[15:8];
    c[1] = first[7:0];
    c[2] = second[15:8];
    c[3] = second[7:0];
    w    = '0;
    for (int g = 0; g < 4; g++) begin
      for (int k = 0; k < 4; k++) begin
        w[31 - 2*(4*g + k) -: 2] = c[3 - k][2*g +: 2];
      end
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// File: sv/pwcfi_encode.sv
`default_nettype none
module pwcfi_encode
  import pwcfi_pkg::*;
(
  input  wire logic         fec_enable,
  input  wire in_item_t     item,
  input  wire coder_state_t state,
  output coder_state_t      state_next,
  output enc_res_t          res
);

  coder_state_t s;
  logic [7:0]   w;
  logic [15:0]  cw;
  logic [15:0]  ct1;
  logic [15:0]  ct2;

  // frame start clears state ahead of this byte
  always_comb begin
    if (item.first_of_frame) begin
      s.lfsr  = LFSR_INIT;
      s.hist  = '0;
      s.held  = '0;
      s.phase = 1'b0;
    end else begin
      s = state;
    end
  end

  // whitening and the three coder passes
  assign w   = item.data_byte ^ s.lfsr[7:0];
  assign cw  = code_byte(s.hist, w);
  assign ct1 = code_byte(w[2:0], TERMINATOR);
  assign ct2 = code_byte(TERM_HIST, TERMINATOR);

  // result items and next state
  always_comb begin
    state_next      = s;
    state_next.lfsr = lfsr_advance(s.lfsr);
    res.nres        = 2'd0;
    res.r0          = '0;
    res.r1          = '0;
    res.r0.out_count = COUNT_CODED;
    res.r1.out_count = COUNT_CODED;
    if (!fec_enable) begin
      res.nres         = 2'd1;
      res.r0.out_word  = {24'd0, w};
      res.r0.out_count = COUNT_PLAIN;
      res.r0.out_last  = item.last_of_frame;
    end else if (!item.last_of_frame) begin
      state_next.hist = w[2:0];
      if (!s.phase) begin
        state_next.held  = cw;
        state_next.phase = 1'b1;
      end else begin
        res.nres         = 2'd1;
        res.r0.out_word  = interleave(s.held, cw);
        state_next.phase = 1'b0;
      end
    end else begin
      state_next.hist  = TERM_HIST;
      state_next.phase = 1'b0;
      if (!s.phase) begin
        // single terminator closes the pair
        res.nres        = 2'd1;
        res.r0.out_word = interleave(cw, ct1);
        res.r0.out_last = 1'b1;
        state_next.held = cw;
      end else begin
        // pair completes, two terminators follow
        res.nres        = 2'd2;
        res.r0.out_word = interleave(s.held, cw);
        res.r1.out_word = interleave(ct1, ct2);
        res.r1.out_last = 1'b1;
        state_next.held = ct1;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/pwcfi_outbuf.sv
`default_nettype none
`include "pn9_whiten_conv_fec_interleave_tx_macros.svh"
module pwcfi_outbuf
  import pwcfi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire enc_res_t push,
  output logic [1:0]    space,
  output logic          word_valid,
  input  wire logic     word_stall,
  output out_item_t     word_item
);

  localparam logic [1:0] DEPTH = 2'(OBUF_DEPTH);

  out_item_t  q0;
  out_item_t  q1;
  out_item_t  q0_next;
  out_item_t  q1_next;
  out_item_t  e0;
  out_item_t  e1;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [1:0] n;
  logic       pop;

  assign word_valid = (cnt != 2'd0);
  assign word_item  = q0;
  assign pop        = word_valid && !word_stall;
  assign space      = DEPTH - cnt + {1'b0, pop};

  // shift out the taken item, then append new ones
  always_comb begin
    if (pop) begin
      e0 = q1;
      e1 = q1;
      n  = cnt - 2'd1;
    end else begin
      e0 = q0;
      e1 = q1;
      n  = cnt;
    end
    q0_next  = (n == 2'd0) ? push.r0 : e0;
    q1_next  = (n == 2'd0) ? push.r1 : ((n == 2'd1) ? push.r0 : e1);
    cnt_next = n + push.nres;
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  `PWCFI_ASSERT(a_push_fits, clk, rst, push.nres <= space)
  `PWCFI_ASSERT_NEXT(a_full_holds, clk, rst, (cnt == DEPTH) && !pop, cnt == DEPTH)
  `PWCFI_ASSERT_NEXT(a_pop_drains, clk, rst, pop && (push.nres == 2'd0), cnt == $past(cnt) - 2'd1)

endmodule
`default_nettype wire

// File: sv/pn9_whiten_conv_fec_interleave_tx.sv
// path: a byte waits in the input register until the output buffer has room for its
//   result items, which are then registered in the buffer and leave from its head slot
// throughput: one byte per cycle while the buffer has room; a coded last byte completing
//   a pair yields two words, which the two-entry buffer drains one per unstalled cycle
// reset (synchronous, active high): whitening only, pn9 register 0x1FF, coder history and
//   pair phase cleared, input register and output buffer empty
`default_nettype none
module pn9_whiten_conv_fec_interleave_tx
  import pwcfi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data,
  input  wire logic      byte_valid,
  output logic           byte_stall,
  input  wire in_item_t  byte_item,
  output logic           word_valid,
  input  wire logic      word_stall,
  output out_item_t      word_item
);

  logic         fec_enable;
  logic         in_full;
  in_item_t     in_reg;
  coder_state_t state;
  coder_state_t state_next;
  enc_res_t     enc_res;
  enc_res_t     push;
  logic [1:0]   space;
  logic         proc;
  logic         accept;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      fec_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      fec_enable <= cfg_data;
    end
  end

  // input register handshake
  assign proc       = in_full && (enc_res.nres <= space);
  assign byte_stall = in_full && !proc;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= byte_item;
    end
  end

  // encoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.lfsr  <= LFSR_INIT;
      state.hist  <= '0;
      state.held  <= '0;
      state.phase <= 1'b0;
    end else if (proc) begin
      state <= state_next;
    end
  end

  pwcfi_encode u_encode (
    .fec_enable (fec_enable),
    .item       (in_reg),
    .state      (state),
    .state_next (state_next),
    .res        (enc_res)
  );

  // only a processed byte pushes results
  always_comb begin
    push      = enc_res;
    push.nres = proc ? enc_res.nres : 2'd0;
  end

  pwcfi_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .space      (space),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word_item  (word_item)
  );

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
module testbench
  import pwcfi_pkg::*;
();

  localparam int CLK_HIGH = 6;
  localparam int CLK_LOW = 6;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_PCT = 21;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int REPORT_MAX = 10;

  // 2-bit code symbol per window of three history bits and the current bit
  localparam logic [1:0] CODE_SYM [16] = '{
    2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1,
    2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_item_t  byte_item = '0;
  logic      word_valid;
  logic      word_stall = 1'b0;
  out_item_t word_item;

  // encoder state as the testbench tracks it
  logic [8:0]  pn9 = LFSR_INIT;
  logic [2:0]  trellis = '0;
  logic [15:0] half_pair = '0;
  logic        pair_held = 1'b0;
  logic        fec_mode = 1'b0;

  in_item_t    bytes_to_send [$];
  out_item_t   expected_words [$];
  logic [31:0] staged_words [$];

  logic steady = 1'b0;
  logic hold_request = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   bytes_taken = 0;
  int   words_checked = 0;
  int   coded_words = 0;
  int   fail_count = 0;
  int   holds_done = 0;

  pn9_whiten_conv_fec_interleave_tx dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word_item  (word_item)
  );

  // clock
  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW clk = 1'b0;
  end

  // pn9 x^9 + x^5 + 1, eight single steps
  function automatic logic [8:0] pn9_next8(input logic [8:0] r);
    for (int s = 0; s < 8; s++) r = {r[0] ^ r[5], r[8:1]};
    return r;
  endfunction

  // rate one half code of a byte, history bits on top, msb first
  function automatic logic [15:0] conv_code(input logic [2:0] hist, input logic [7:0] v,
                                            output logic [2:0] hist_out);
    logic [10:0] window;
    logic [15:0] sym;
    window = {hist, v};
    sym = '0;
    for (int n = 0; n < 8; n++) begin
      sym = {sym[13:0], CODE_SYM[window[10:7]]};
      window = window << 1;
    end
    hist_out = window[10:8];
    return sym;
  endfunction

  // two coded pairs into one word, 2-bit groups from the last byte backward
  function automatic logic [31:0] mix_pair(input logic [15:0] a, input logic [15:0] b);
    logic [7:0]  cb [4];
    logic [31:0] w;
    cb[0] = a[15:8];
    cb[1] = a[7:0];
    cb[2] = b[15:8];
    cb[3] = b[7:0];
    w = '0;
    for (int g = 0; g < 4; g++)
      for (int k = 3; k >= 0; k--) w = {w[29:0], cb[k][2*g +: 2]};
    return w;
  endfunction

  // code one byte into the pair buffer, staging a word when the pair completes
  task automatic pair_code(input logic [7:0] v);
    logic [15:0] cw;
    logic [2:0]  h;
    cw = conv_code(trellis, v, h);
    trellis = h;
    if (!pair_held) begin
      half_pair = cw;
      pair_held = 1'b1;
    end else begin
      staged_words.push_back(mix_pair(half_pair, cw));
      pair_held = 1'b0;
    end
  endtask

  // expected words for one accepted byte
  task automatic predict_byte(input in_item_t it);
    logic [7:0] w;
    out_item_t  r;
    if (it.first_of_frame) begin
      pn9 = LFSR_INIT;
      trellis = '0;
      half_pair = '0;
      pair_held = 1'b0;
    end
    w = it.data_byte ^ pn9[7:0];
    pn9 = pn9_next8(pn9);
    if (!fec_mode) begin
      r.out_word = {24'd0, w};
      r.out_count = COUNT_PLAIN;
      r.out_last = it.last_of_frame;
      expected_words.push_back(r);
    end else begin
      staged_words.delete();
      pair_code(w);
      // terminators pad the coded frame to an even byte count
      if (it.last_of_frame) begin
        pair_code(TERMINATOR);
        if (pair_held) pair_code(TERMINATOR);
      end
      foreach (staged_words[i]) begin
        r.out_word = staged_words[i];
        r.out_count = COUNT_CODED;
        r.out_last = it.last_of_frame && (i == staged_words.size() - 1);
        expected_words.push_back(r);
      end
    end
  endtask

  function automatic in_item_t byte_of(input logic [7:0] d, input logic f, input logic l);
    in_item_t it;
    it.data_byte = d;
    it.first_of_frame = f;
    it.last_of_frame = l;
    return it;
  endfunction

  // one frame of random bytes, optionally missing its first or last mark
  task automatic queue_frame(input int len, input logic with_first, input logic with_last);
    for (int i = 0; i < len; i++)
      bytes_to_send.push_back(byte_of(8'($urandom_range(255)), with_first && (i == 0),
                                      with_last && (i == len - 1)));
  endtask

  // mostly well-formed frames, some broken frames and loose bytes
  task automatic queue_random(input int target);
    int n;
    int pick;
    int len;
    n = 0;
    while (n < target) begin
      pick = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(10, 1);
      if (pick < 75) begin
        queue_frame(len, 1'b1, 1'b1);
        n += len;
      end else if (pick < 85) begin
        queue_frame(len, 1'($urandom_range(1)), 1'($urandom_range(1)));
        n += len;
      end else begin
        bytes_to_send.push_back(byte_of(8'($urandom_range(255)), 1'($urandom_range(1)),
                                        1'($urandom_range(1))));
        n++;
      end
    end
  endtask

  // mode register write, only while the block is idle
  task automatic set_fec(input logic val);
    @(posedge clk);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fec_mode = val;
  endtask

  // sender pauses until every expected word is back, then lets the block settle
  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || byte_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        predict_byte(byte_item);
        bytes_taken++;
      end
      if (!byte_valid || !byte_stall) begin
        if (bytes_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          byte_item <= bytes_to_send.pop_front();
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // word monitor and receiver stall
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      word_stall <= 1'b0;
    end else begin
      if (word_valid && !word_stall) begin
        words_checked++;
        if (word_item.out_count == COUNT_CODED) coded_words++;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected item: word %h count %0d last %0b", word_item.out_word,
                     word_item.out_count, word_item.out_last);
        end else begin
          want = expected_words.pop_front();
          if (word_item.out_word !== want.out_word || word_item.out_count !== want.out_count ||
              word_item.out_last !== want.out_last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("mismatch at item %0d: expected word %h count %0d last %0b, got %h %0d %0b",
                       words_checked, want.out_word, want.out_count, want.out_last,
                       word_item.out_word, word_item.out_count, word_item.out_last);
          end
        end
      end
      // long hold-off on request, otherwise random stalls outside the steady phase
      if (hold_left != 0) begin
        word_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        holds_done++;
        word_stall <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
      end else begin
        word_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected", cycle_count,
               expected_words.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // whitening only: single-byte frame, extremes, byte with no first mark
    set_fec(1'b0);
    bytes_to_send.push_back(byte_of(8'h00, 1'b1, 1'b1));
    bytes_to_send.push_back(byte_of(8'hFF, 1'b1, 1'b0));
    bytes_to_send.push_back(byte_of(8'h5A, 1'b0, 1'b0));
    bytes_to_send.push_back(byte_of(8'hC3, 1'b0, 1'b1));
    bytes_to_send.push_back(byte_of(8'h80, 1'b0, 1'b0));
    wait_drained();

    // coded: one and two terminators, odd frame, continuation after end, held half pair
    set_fec(1'b1);
    bytes_to_send.push_back(byte_of(8'hFF, 1'b1, 1'b1));
    bytes_to_send.push_back(byte_of(8'h00, 1'b1, 1'b0));
    bytes_to_send.push_back(byte_of(8'hFF, 1'b0, 1'b1));
    bytes_to_send.push_back(byte_of(8'hA5, 1'b1, 1'b0));
    bytes_to_send.push_back(byte_of(8'h3C, 1'b0, 1'b0));
    bytes_to_send.push_back(byte_of(8'h7E, 1'b0, 1'b1));
    bytes_to_send.push_back(byte_of(8'h01, 1'b0, 1'b0));
    bytes_to_send.push_back(byte_of(8'h55, 1'b1, 1'b0));
    wait_drained();

    // mode switch mid-frame: held coded byte waits while whitening continues
    set_fec(1'b0);
    bytes_to_send.push_back(byte_of(8'h12, 1'b0, 1'b0));
    bytes_to_send.push_back(byte_of(8'hF0, 1'b0, 1'b1));
    wait_drained();
    set_fec(1'b1);
    bytes_to_send.push_back(byte_of(8'h34, 1'b0, 1'b0));
    bytes_to_send.push_back(byte_of(8'h9C, 1'b0, 1'b1));
    wait_drained();

    // random phases, alternating mode
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_fec(p % 2 == 0);
      steady = (p == 3);
      queue_random(PHASE_ITEMS);
      if (p == 2 || p == 5) hold_request = 1'b1;
      wait_drained();
      steady = 1'b0;
    end

    $display("covered %0d bytes in both modes, %0d items checked (%0d coded words)",
             bytes_taken, words_checked, coded_words);
    $display("%0d long receiver hold-offs, %0d failures", holds_done, fail_count);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/pwcfi_pkg.sv
sv/pwcfi_encode.sv
sv/pwcfi_outbuf.sv
sv/pn9_whiten_conv_fec_interleave_tx.sv
sim/testbench.sv
